// ===== rtl/bde_pkg.sv =====
package bde_pkg;

    localparam int DEPTH  = 16;
    localparam int WORD_W = 64;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [2:0] MODE_POP_BACK   = 3'd3;
    localparam logic [2:0] MODE_ERASE      = 3'd4;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]        mode;
        logic [WORD_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [4:0]        occupancy;
        logic              is_empty;
        logic [WORD_W-1:0] front_word;
        logic [WORD_W-1:0] back_word;
        logic [4:0]        removed_count;
    } rsp_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic              load_front;
        logic              write_back;
        logic              erase;
        logic [WORD_W-1:0] data;
    } cell_ctl_t;

endpackage

// ===== rtl/bde_cell.sv =====
module bde_cell
    import bde_pkg::*;
(
    input  logic              aclk,
    input  cell_ctl_t         ctl,
    input  logic              live,
    input  logic              tail,
    input  logic [WORD_W-1:0] left_word,
    input  logic [WORD_W-1:0] right_word,
    input  logic              chain_in,
    output logic              chain_out,
    output logic [WORD_W-1:0] word
);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic              match;

    // a match here, or anywhere to the left, pulls the right neighbour in
    assign match     = ctl.erase && live && (word_reg == ctl.data);
    assign chain_out = chain_in || match;
    assign word      = word_reg;

    always_comb begin
        word_next = word_reg;
        if (ctl.load_front) begin
            word_next = left_word;
        end else if (chain_out) begin
            word_next = right_word;
        end else if (ctl.write_back && tail) begin
            word_next = ctl.data;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

endmodule

// ===== rtl/bounded_deque_with_erase.sv =====
// channel    | direction | ports                     | contents
// -----------+-----------+---------------------------+---------------------------------
// request    | in        | s_valid, s_ready, s_req   | mode, value
// result     | out       | m_valid, m_ready, m_rsp   | status, occupancy, empty, ends,
//            |           |                           | removed count
//
// for push and pop front the row of cells moves in the accept cycle, pop back only
// lowers the fill count; the result is built from the updated state in the next one.
// erase runs the compare-and-shift row, which removes the leftmost match each cycle
// until no live entry matches; the result is then built from the compacted row.
// aresetn (synchronous, active low) empties the deque; cell contents are not cleared.
// a request is taken only when the previous result has left or is leaving, so a
// stalled result holds back the next request.
module bounded_deque_with_erase
    import bde_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_req,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ERASE,
        S_REPORT
    } state_t;

    state_t              state_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   removed_reg;
    logic [1:0]          status_reg;
    logic [WORD_W-1:0]   key_reg;
    logic                m_valid_reg;
    rsp_t                m_rsp_reg;

    cell_ctl_t           cell_ctl;
    logic                chain_head;
    logic [DEPTH:0]      chain;
    logic [WORD_W-1:0]   words [DEPTH];
    logic                accept;
    logic                full;
    logic                empty;
    logic                any_match;
    logic [IDX_W-1:0]    last_idx;

    assign full      = (fill_reg == FILL_W'(DEPTH));
    assign empty     = (fill_reg == '0);
    assign s_ready   = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_rsp     = m_rsp_reg;
    assign chain[0]  = chain_head;
    // during erase the shift chain leaves the last cell set only when some live entry matched
    assign any_match = chain[DEPTH];
    assign last_idx  = IDX_W'(fill_reg - FILL_W'(1));

    // command for the row of cells: request decode in idle, compaction step in erase
    always_comb begin
        cell_ctl            = '0;
        cell_ctl.data       = s_req.value;
        chain_head          = 1'b0;
        if (state_reg == S_IDLE && accept) begin
            unique case (s_req.mode)
                MODE_PUSH_FRONT: cell_ctl.load_front = !full;
                MODE_PUSH_BACK:  cell_ctl.write_back = !full;
                MODE_POP_FRONT:  chain_head          = !empty;
                default: ;
            endcase
        end else if (state_reg == S_ERASE) begin
            cell_ctl.erase = 1'b1;
            cell_ctl.data  = key_reg;
        end
    end

    // the row: slot 0 is the front, every inner cell sees both neighbours
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = cell_ctl.data;
        end else begin : g_left
            assign left_w = words[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_right
            assign right_w = words[i+1];
        end

        bde_cell u_cell (
            .aclk       (aclk),
            .ctl        (cell_ctl),
            .live       (FILL_W'(i) < fill_reg),
            .tail       (FILL_W'(i) == fill_reg),
            .left_word  (left_w),
            .right_word (right_w),
            .chain_in   (chain[i]),
            .chain_out  (chain[i+1]),
            .word       (words[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        key_reg <= s_req.value;
                        unique case (s_req.mode) inside
                            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                                removed_reg <= '0;
                                state_reg   <= S_REPORT;
                                if (full) begin
                                    status_reg <= STATUS_FULL;
                                end else begin
                                    status_reg <= STATUS_DONE;
                                    fill_reg   <= fill_reg + FILL_W'(1);
                                end
                            end
                            MODE_POP_FRONT, MODE_POP_BACK: begin
                                state_reg <= S_REPORT;
                                if (empty) begin
                                    status_reg  <= STATUS_EMPTY;
                                    removed_reg <= '0;
                                end else begin
                                    status_reg  <= STATUS_DONE;
                                    fill_reg    <= fill_reg - FILL_W'(1);
                                    removed_reg <= FILL_W'(1);
                                end
                            end
                            MODE_ERASE: begin
                                status_reg  <= STATUS_DONE;
                                removed_reg <= '0;
                                state_reg   <= S_ERASE;
                            end
                            default: begin
                                // unused mode codes only report the contents
                                status_reg  <= STATUS_DONE;
                                removed_reg <= '0;
                                state_reg   <= S_REPORT;
                            end
                        endcase
                    end
                end
                S_ERASE: begin
                    // one match leaves the row per cycle
                    if (any_match) begin
                        fill_reg    <= fill_reg - FILL_W'(1);
                        removed_reg <= removed_reg + FILL_W'(1);
                    end else begin
                        state_reg <= S_REPORT;
                    end
                end
                S_REPORT: begin
                    m_valid_reg                <= 1'b1;
                    m_rsp_reg.status           <= status_reg;
                    m_rsp_reg.occupancy        <= 5'(fill_reg);
                    m_rsp_reg.is_empty         <= empty;
                    m_rsp_reg.front_word       <= empty ? '0 : words[0];
                    m_rsp_reg.back_word        <= empty ? '0 : words[last_idx];
                    m_rsp_reg.removed_count    <= 5'(removed_reg);
                    state_reg                  <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // occupancy never passes the row length
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(DEPTH))
        else $error("fill count beyond depth");

    // compaction never grows the deque
    a_erase_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ERASE |=> fill_reg <= $past(fill_reg))
        else $error("fill count grew during erase");

    // a result only appears from the report step
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_REPORT))
        else $error("result raised outside report step");

    // no request is taken while a result is still held back
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !s_ready)
        else $error("request taken over a stalled result");

endmodule
